// File: src/complex_arithmetic_unit_top_macros.svh
// Assertion helpers, clocked on clk, quiet while arst_n is low.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/cau_pkg.sv
`default_nettype none
package cau_pkg;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	// product / sum widths
	localparam int SW = 2 * DATA_WIDTH;
	localparam int VW = SW + 1;
	// quotient bits; a quotient of 2^QB or more is replaced by 2^DATA_WIDTH
	localparam int QB = DATA_WIDTH + 1;
	// remainder width of the divider
	localparam int RW = VW + FRAC_BITS + QB;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]                   func;
		logic signed [DATA_WIDTH-1:0] a_real;
		logic signed [DATA_WIDTH-1:0] a_imag;
		logic signed [DATA_WIDTH-1:0] b_real;
		logic signed [DATA_WIDTH-1:0] b_imag;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res_real;
		logic signed [DATA_WIDTH-1:0] res_imag;
		logic [1:0]                   status;
	} out_word_t;

	// classified command held in the queue
	typedef struct packed {
		in_word_t w;
		logic     divz;
	} cmd_t;

	typedef struct packed {
		logic push;
	} qctl_t;
endpackage
`default_nettype wire

// File: src/cau_front.sv
`default_nettype none
module cau_front import cau_pkg::*; (
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire in_word_t req_word,
	input  wire logic     q_full,
	output qctl_t         qctl,
	output cmd_t          cmd
);
	// zero divisor detected up front so the back end only carries a flag
	always_comb begin
		cmd.w     = req_word;
		cmd.divz  = (req_word.func == FUNC_DIV) &&
		            (req_word.b_real == '0) && (req_word.b_imag == '0);
		req_stall = q_full;
		qctl.push = req_valid && !q_full;
	end
endmodule
`default_nettype wire

// File: src/cau_queue.sv
`default_nettype none
module cau_queue import cau_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire qctl_t qctl,
	input  wire cmd_t  wr_cmd,
	output logic       full,
	output logic       rd_valid,
	output cmd_t       rd_cmd,
	input  wire logic  pop
);
`include "complex_arithmetic_unit_top_macros.svh"
	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_pop;

	assign full     = (cnt_q == (QAW+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (qctl.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!qctl.push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CAU_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= (QAW+1)'(QDEPTH))
	`CAU_ASSERT_NEXT(a_full_holds, full && !do_pop, full)
	`CAU_ASSERT_NEXT(a_empty_holds, !rd_valid && !qctl.push, !rd_valid)
endmodule
`default_nettype wire

// File: src/cau_back.sv
`default_nettype none
module cau_back import cau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire cmd_t q_cmd,
	output logic      pop,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output out_word_t rsp_word
);
`include "complex_arithmetic_unit_top_macros.svh"
	typedef struct packed {
		logic [1:0]    func;
		logic          divz;
		logic          neg_re;
		logic          neg_im;
		logic          cap_re;
		logic          cap_im;
		logic [VW-1:0] mag_re;
		logic [VW-1:0] mag_im;
		logic [SW-1:0] d;
		logic [RW-1:0] r_re;
		logic [RW-1:0] r_im;
		logic [QB-1:0] q_re;
		logic [QB-1:0] q_im;
	} dstage_t;

	localparam logic [VW-1:0] MAXP = VW'((64'd1 << (DATA_WIDTH-1)) - 64'd1);
	localparam logic [VW-1:0] MAXN = VW'(64'd1 << (DATA_WIDTH-1));
	localparam logic [VW-1:0] CAPV = VW'(64'd1 << DATA_WIDTH);

	logic adv;

	// s1: products and add/sub
	logic                 v_s1;
	logic [1:0]           func_s1;
	logic                 divz_s1;
	logic signed [SW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;
	logic signed [SW-1:0] as_re_s1, as_im_s1;
	// s2: sums and differences
	logic                 v_s2;
	logic [1:0]           func_s2;
	logic                 divz_s2;
	logic signed [VW-1:0] re_s2, im_s2;
	logic [SW-1:0]        d_s2;
	// s3: sign/magnitude, divider setup
	logic                 v_s3;
	dstage_t              st_s3;
	// divider stages, one quotient bit each
	logic                 dv_v_q  [QB];
	dstage_t              dv_q    [QB];
	dstage_t              dv_nxt  [QB];
	// output
	logic                 out_valid_q;
	out_word_t            out_q;

	logic [VW-1:0] abs_re, abs_im;
	logic [VW-1:0] fin_re, fin_im;
	logic [VW-1:0] neg_t_re, neg_t_im;
	logic          ovf_re, ovf_im;
	out_word_t     out_d;
	dstage_t       lst;

	assign adv       = !out_valid_q || !rsp_stall;
	assign pop       = adv && q_valid;
	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= q_cmd.w.func;
			divz_s1  <= q_cmd.divz;
			p_rr_s1  <= SW'(q_cmd.w.a_real) * SW'(q_cmd.w.b_real);
			p_ii_s1  <= SW'(q_cmd.w.a_imag) * SW'(q_cmd.w.b_imag);
			p_ri_s1  <= SW'(q_cmd.w.a_real) * SW'(q_cmd.w.b_imag);
			p_ir_s1  <= SW'(q_cmd.w.a_imag) * SW'(q_cmd.w.b_real);
			sq_r_s1  <= SW'(q_cmd.w.b_real) * SW'(q_cmd.w.b_real);
			sq_i_s1  <= SW'(q_cmd.w.b_imag) * SW'(q_cmd.w.b_imag);
			if (q_cmd.w.func == FUNC_SUB) begin
				as_re_s1 <= SW'(q_cmd.w.a_real) - SW'(q_cmd.w.b_real);
				as_im_s1 <= SW'(q_cmd.w.a_imag) - SW'(q_cmd.w.b_imag);
			end else begin
				as_re_s1 <= SW'(q_cmd.w.a_real) + SW'(q_cmd.w.b_real);
				as_im_s1 <= SW'(q_cmd.w.a_imag) + SW'(q_cmd.w.b_imag);
			end

			func_s2 <= func_s1;
			divz_s2 <= divz_s1;
			d_s2    <= $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
			case (func_s1)
				FUNC_MUL: begin
					re_s2 <= VW'(p_rr_s1) - VW'(p_ii_s1);
					im_s2 <= VW'(p_ri_s1) + VW'(p_ir_s1);
				end
				FUNC_DIV: begin
					re_s2 <= VW'(p_rr_s1) + VW'(p_ii_s1);
					im_s2 <= VW'(p_ir_s1) - VW'(p_ri_s1);
				end
				default: begin
					re_s2 <= VW'(as_re_s1);
					im_s2 <= VW'(as_im_s1);
				end
			endcase

			st_s3.func   <= func_s2;
			st_s3.divz   <= divz_s2;
			st_s3.neg_re <= re_s2[VW-1];
			st_s3.neg_im <= im_s2[VW-1];
			st_s3.d      <= d_s2;
			st_s3.q_re   <= '0;
			st_s3.q_im   <= '0;
			st_s3.r_re   <= RW'(abs_re) << FRAC_BITS;
			st_s3.r_im   <= RW'(abs_im) << FRAC_BITS;
			st_s3.cap_re <= (RW'(abs_re) << FRAC_BITS) >= (RW'(d_s2) << QB);
			st_s3.cap_im <= (RW'(abs_im) << FRAC_BITS) >= (RW'(d_s2) << QB);
			if (func_s2 == FUNC_MUL) begin
				st_s3.mag_re <= abs_re >> FRAC_BITS;
				st_s3.mag_im <= abs_im >> FRAC_BITS;
			end else begin
				st_s3.mag_re <= abs_re;
				st_s3.mag_im <= abs_im;
			end

			dv_q[0] <= st_s3;
			for (int j = 1; j < QB; j++) begin
				dv_q[j] <= dv_nxt[j-1];
			end
			out_q <= out_d;
		end
	end

	assign abs_re = re_s2[VW-1] ? VW'(-re_s2) : VW'(re_s2);
	assign abs_im = im_s2[VW-1] ? VW'(-im_s2) : VW'(im_s2);

	// restoring division, bit QB-1-j resolved in stage j
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			dv_nxt[j] = dv_q[j];
			if (dv_q[j].r_re >= (RW'(dv_q[j].d) << (QB-1-j))) begin
				dv_nxt[j].r_re = dv_q[j].r_re - (RW'(dv_q[j].d) << (QB-1-j));
				dv_nxt[j].q_re[QB-1-j] = 1'b1;
			end
			if (dv_q[j].r_im >= (RW'(dv_q[j].d) << (QB-1-j))) begin
				dv_nxt[j].r_im = dv_q[j].r_im - (RW'(dv_q[j].d) << (QB-1-j));
				dv_nxt[j].q_im[QB-1-j] = 1'b1;
			end
		end
	end

	// saturate and pack
	always_comb begin
		lst = dv_nxt[QB-1];
		if (lst.func == FUNC_DIV) begin
			fin_re = lst.cap_re ? CAPV : VW'(lst.q_re);
			fin_im = lst.cap_im ? CAPV : VW'(lst.q_im);
		end else begin
			fin_re = lst.mag_re;
			fin_im = lst.mag_im;
		end
		ovf_re = lst.neg_re ? (fin_re > MAXN) : (fin_re > MAXP);
		ovf_im = lst.neg_im ? (fin_im > MAXN) : (fin_im > MAXP);
		neg_t_re = lst.neg_re ? (ovf_re ? MAXN : fin_re) : (ovf_re ? MAXP : fin_re);
		neg_t_im = lst.neg_im ? (ovf_im ? MAXN : fin_im) : (ovf_im ? MAXP : fin_im);
		if (lst.neg_re) begin
			neg_t_re = ~neg_t_re + VW'(1);
		end
		if (lst.neg_im) begin
			neg_t_im = ~neg_t_im + VW'(1);
		end
		out_d.res_real = neg_t_re[DATA_WIDTH-1:0];
		out_d.res_imag = neg_t_im[DATA_WIDTH-1:0];
		out_d.status   = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
		if (lst.divz) begin
			out_d.res_real = '0;
			out_d.res_imag = '0;
			out_d.status   = ST_DIVZ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < QB; j++) begin
				dv_v_q[j] <= 1'b0;
			end
		end else if (adv) begin
			v_s1      <= q_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			dv_v_q[0] <= v_s3;
			for (int j = 1; j < QB; j++) begin
				dv_v_q[j] <= dv_v_q[j-1];
			end
			out_valid_q <= dv_v_q[QB-1];
		end
	end

	`CAU_ASSERT_IMPL(a_divz_zero, out_valid_q && out_q.status == ST_DIVZ,
		out_q.res_real == '0 && out_q.res_imag == '0)
	`CAU_ASSERT_IMPL(a_ovf_limit, out_valid_q && out_q.status == ST_OVF,
		out_q.res_real == MAXP[DATA_WIDTH-1:0] || out_q.res_real == MAXN[DATA_WIDTH-1:0] ||
		out_q.res_imag == MAXP[DATA_WIDTH-1:0] || out_q.res_imag == MAXN[DATA_WIDTH-1:0])
	`CAU_ASSERT_NEXT(a_load, dv_v_q[QB-1] && adv, out_valid_q)
endmodule
`default_nettype wire

// File: src/complex_arithmetic_unit_top.sv
// Complex add/sub/mul/div on signed Q8.8 operands, one word in and one out.
// Path: queue, stages s1-s3, one divider stage per quotient bit, output register.
// Throughput: one word per cycle unless rsp_stall holds back a valid result.
// Reset: arst_n asynchronous active low clears all valid flags and queue pointers.
// Payload registers are not reset.
`default_nettype none
module complex_arithmetic_unit_top import cau_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire in_word_t  req_word,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output out_word_t      rsp_word
);
	// front: classify incoming word (zero divisor) and push into queue
	qctl_t qctl;
	cmd_t  push_cmd;
	cmd_t  head_cmd;
	logic  q_full;
	logic  q_valid;
	logic  pop;

	cau_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.q_full    (q_full),
		.qctl      (qctl),
		.cmd       (push_cmd)
	);

	// short queue decouples input acceptance from back-end stalls
	cau_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.qctl     (qctl),
		.wr_cmd   (push_cmd),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_cmd   (head_cmd),
		.pop      (pop)
	);

	// back: multiply, sum, pipelined divide, saturate, output register
	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (head_cmd),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);
endmodule
`default_nettype wire
